FILE: rtl/core/sfla_pkg.sv
// Package for the slab free-list allocator: operation and status codes,
// sizing constants and shared command/status types. No dependencies.
package sfla_pkg;
  localparam int ITEMS_PER_BLOCK_DEF = 10;
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int COUNT_MAX = 15;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE = 2'd1,
    OP_SQUEEZE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LATCH,
    CMD_SCAN_RD,
    CMD_SCAN_CHK,
    CMD_FIND_IDLE,
    CMD_BUILD,
    CMD_POP_RD,
    CMD_POP_WR,
    CMD_FREE_WR,
    CMD_SQ_CHK,
    CMD_SQ_END,
    CMD_DONE_OK,
    CMD_DONE_EXH,
    CMD_DONE_BAD
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic scan_hit;
    logic idle_found;
    logic build_end;
    logic free_bad;
  } dp_status_t;
endpackage

FILE: rtl/core/sfla_stream_if.sv
// Valid/ready channel carrying one payload word of type payload_t.
// Depends on nothing beyond the type parameter.
interface sfla_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/sfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfla_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/sfla_datapath.sv
// Datapath of the slab allocator: block tables, item link RAM, scan pointer
// and result registers. Uses sfla_pkg and sfla_ram; driven by sfla_ctrl.
module sfla_datapath #(
  parameter int ITEMS_PER_BLOCK = sfla_pkg::ITEMS_PER_BLOCK_DEF,
  parameter int MAX_BLOCKS = sfla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sfla_pkg::cmd_t        cmd,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_item_handle,
  output sfla_pkg::dp_status_t  sts,
  output logic [7:0]            given_handle,
  output logic [1:0]            status,
  output logic [3:0]            blocks_released
);
  import sfla_pkg::*;

  localparam int TOTAL = MAX_BLOCKS * ITEMS_PER_BLOCK;
  localparam int SW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int KW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(TOTAL);
  localparam int HW = 14;

  logic [3:0]    list_head [MAX_BLOCKS];
  logic [3:0]    free_count [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] slot_active;
  logic [SW-1:0] block_order [MAX_BLOCKS];
  logic [KW-1:0] active_blocks;
  logic [KW-1:0] k;
  logic [KW-1:0] kept;
  logic [SW-1:0] slot;
  logic [3:0]    idx;
  logic [3:0]    rel;
  logic [7:0]    handle;
  logic [3:0]    bi;
  logic          bad;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [3:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [3:0]    ram_rdata;
  logic [AW-1:0] base;
  logic [HW-1:0] prod;
  logic [SW-1:0] h_slot;
  logic [3:0]    h_idx;
  logic [SW-1:0] cur_slot;
  logic [SW-1:0] lowest_idle;
  logic          idle_any;
  logic [3:0]    pop_idx;

  // handle / ITEMS_PER_BLOCK by reciprocal multiply with one correction
  localparam int RECIP = (1 << HW) / ITEMS_PER_BLOCK + 1;
  logic [HW+8-1:0] q_full;
  logic [7:0]      q0;
  logic [8:0]      r0;
  always_comb begin
    q_full = {{HW{1'b0}}, in_item_handle} * (HW + 8)'(RECIP);
    q0 = 8'(q_full >> HW);
    r0 = 9'(in_item_handle) - 9'(q0 * 8'(ITEMS_PER_BLOCK));
    if (r0[8]) begin
      q0 = q0 - 8'd1;
      r0 = r0 + 9'(ITEMS_PER_BLOCK);
    end else if (r0 >= 9'(ITEMS_PER_BLOCK)) begin
      q0 = q0 + 8'd1;
      r0 = r0 - 9'(ITEMS_PER_BLOCK);
    end
    h_slot = SW'(q0);
    h_idx = 4'(r0);
  end

  assign cur_slot = block_order[k[SW-1:0]];
  assign prod = HW'(slot) * HW'(ITEMS_PER_BLOCK);
  assign base = AW'(prod);
  assign pop_idx = (list_head[slot] >= 4'(ITEMS_PER_BLOCK)) ?
                   list_head[slot] - 4'(ITEMS_PER_BLOCK) : list_head[slot];

  always_comb begin
    lowest_idle = '0;
    idle_any = 1'b0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        lowest_idle = SW'(i);
        idle_any = 1'b1;
      end
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = base + AW'(bi);
    ram_wdata = 4'(bi + 4'd1);
    ram_raddr = base + AW'(pop_idx);
    case (cmd)
      CMD_BUILD: ram_we = 1'b1;
      CMD_FREE_WR: begin
        ram_we = !bad;
        ram_waddr = base + AW'(idx);
        ram_wdata = list_head[slot];
      end
      default: ;
    endcase
  end

  sfla_ram #(.WIDTH(4), .DEPTH(TOTAL)) u_link (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    sts.scan_end = (k >= active_blocks) || (k >= KW'(MAX_BLOCKS));
    sts.scan_hit = free_count[cur_slot] != 4'd0;
    sts.idle_found = idle_any && (active_blocks < KW'(MAX_BLOCKS));
    sts.build_end = bi == 4'(ITEMS_PER_BLOCK - 1);
    sts.free_bad = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        list_head[i] <= '0;
        free_count[i] <= '0;
        block_order[i] <= '0;
      end
      slot_active <= '0;
      active_blocks <= '0;
      k <= '0;
      kept <= '0;
      slot <= '0;
      idx <= '0;
      rel <= '0;
      handle <= '0;
      bi <= '0;
      bad <= 1'b0;
      given_handle <= '0;
      status <= '0;
      blocks_released <= '0;
    end else begin
      case (cmd)
        CMD_LATCH: begin
          k <= '0;
          kept <= KW'(1);
          rel <= '0;
          bi <= '0;
          slot <= h_slot;
          idx <= h_idx;
          bad <= (in_item_handle >= 8'(TOTAL)) || !slot_active[h_slot];
          if (in_operation == OP_SQUEEZE) begin
            k <= KW'(1);
          end
        end
        CMD_SCAN_RD: slot <= cur_slot;
        CMD_SCAN_CHK: begin
          if (sts.scan_end || !sts.scan_hit) begin
            k <= k + KW'(1);
          end
        end
        CMD_FIND_IDLE: slot <= lowest_idle;
        CMD_BUILD: begin
          bi <= bi + 4'd1;
          if (sts.build_end) begin
            list_head[slot] <= '0;
            free_count[slot] <= 4'(ITEMS_PER_BLOCK);
            slot_active[slot] <= 1'b1;
            block_order[active_blocks[SW-1:0]] <= slot;
            active_blocks <= active_blocks + KW'(1);
          end
        end
        CMD_POP_RD: ;
        CMD_POP_WR: begin
          handle <= 8'(base + AW'(pop_idx));
          list_head[slot] <= ram_rdata;
          free_count[slot] <= free_count[slot] - 4'd1;
        end
        CMD_FREE_WR: begin
          if (!bad) begin
            list_head[slot] <= idx;
            if (free_count[slot] < 4'(COUNT_MAX)) begin
              free_count[slot] <= free_count[slot] + 4'd1;
            end
          end
        end
        CMD_SQ_CHK: begin
          if (!sts.scan_end) begin
            k <= k + KW'(1);
            if (cur_slot != '0 && free_count[cur_slot] == 4'(ITEMS_PER_BLOCK)) begin
              slot_active[cur_slot] <= 1'b0;
              free_count[cur_slot] <= '0;
              list_head[cur_slot] <= '0;
              rel <= rel + 4'd1;
            end else begin
              block_order[kept[SW-1:0]] <= cur_slot;
              kept <= kept + KW'(1);
            end
          end
        end
        CMD_SQ_END: begin
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (KW'(i) >= kept) begin
              block_order[i] <= '0;
            end
          end
          active_blocks <= kept;
          given_handle <= '0;
          status <= ST_OK;
          blocks_released <= rel;
        end
        CMD_DONE_OK: begin
          given_handle <= (in_operation == OP_ALLOC) ? handle : 8'd0;
          status <= ST_OK;
          blocks_released <= '0;
        end
        CMD_DONE_EXH: begin
          given_handle <= '0;
          status <= ST_EXHAUSTED;
          blocks_released <= '0;
        end
        CMD_DONE_BAD: begin
          given_handle <= '0;
          status <= ST_BAD_FREE;
          blocks_released <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/core/sfla_ctrl.sv
// Sequencer of the slab allocator: handshakes and command issue.
// Uses sfla_pkg; drives sfla_datapath.
module sfla_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sfla_pkg::dp_status_t sts,
  output sfla_pkg::cmd_t       cmd
);
  import sfla_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LATCH, S_SCAN_RD, S_SCAN_CHK, S_FIND, S_BUILD, S_POP_RD,
    S_POP_WR, S_FREE, S_SQ, S_SQ_END, S_OK, S_EXH, S_BAD, S_OUT, S_INIT
  } state_t;

  state_t state;
  logic [1:0] op;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_LATCH: cmd = CMD_LATCH;
      S_SCAN_RD: cmd = CMD_SCAN_RD;
      S_SCAN_CHK: cmd = CMD_SCAN_CHK;
      S_FIND: cmd = CMD_FIND_IDLE;
      S_BUILD, S_INIT: cmd = CMD_BUILD;
      S_POP_RD: cmd = CMD_POP_RD;
      S_POP_WR: cmd = CMD_POP_WR;
      S_FREE: cmd = CMD_FREE_WR;
      S_SQ: cmd = CMD_SQ_CHK;
      S_SQ_END: cmd = CMD_SQ_END;
      S_OK: cmd = CMD_DONE_OK;
      S_EXH: cmd = CMD_DONE_EXH;
      S_BAD: cmd = CMD_DONE_BAD;
      default: cmd = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      op <= OP_ALLOC;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          if (sts.build_end) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= in_operation;
            state <= S_LATCH;
          end
        end
        S_LATCH: begin
          case (op)
            OP_ALLOC: state <= S_SCAN_CHK;
            OP_FREE: state <= S_FREE;
            OP_SQUEEZE: state <= S_SQ;
            default: state <= S_OK;
          endcase
        end
        S_SCAN_CHK: begin
          if (sts.scan_end) begin
            state <= S_FIND;
          end else if (sts.scan_hit) begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_POP_RD;
        S_FIND: state <= sts.idle_found ? S_BUILD : S_EXH;
        S_BUILD: begin
          if (sts.build_end) begin
            state <= S_POP_RD;
          end
        end
        S_POP_RD: state <= S_POP_WR;
        S_POP_WR: state <= S_OK;
        S_FREE: state <= sts.free_bad ? S_BAD : S_OK;
        S_SQ: begin
          if (sts.scan_end) begin
            state <= S_SQ_END;
          end
        end
        S_SQ_END, S_OK, S_EXH, S_BAD: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/slab_free_list_allocator_unit.sv
// Slab free-list allocator over MAX_BLOCKS block slots. One transaction at a
// time. After reset the head block's links are built, which holds req.ready low
// until that build is done. An allocate scans the block table in order up to
// the first block with a free item, plus a closing step when none has one;
// then it builds a new block if an idle slot is left, or else reports the pool
// exhausted. The item is popped through the registered read of the link RAM.
// A valid free pushes the item back onto its block's list; squeeze visits each
// active block after the head block. The result is held until taken and the
// next transaction can be accepted in the cycle after it is taken. Uses
// sfla_pkg, sfla_stream_if, sfla_ctrl and sfla_datapath.
module slab_free_list_allocator_unit #(
  parameter int ITEMS_PER_BLOCK = sfla_pkg::ITEMS_PER_BLOCK_DEF,
  parameter int MAX_BLOCKS = sfla_pkg::MAX_BLOCKS_DEF
) (
  input logic clk,
  input logic rst,
  sfla_stream_if.sink req,
  sfla_stream_if.source rsp
);
  import sfla_pkg::*;

  cmd_t cmd;
  dp_status_t sts;
  logic [1:0] op_q;
  logic [7:0] handle_q;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q <= req.payload.operation;
      handle_q <= req.payload.item_handle;
    end
  end

  sfla_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready), .in_operation(req.payload.operation),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  sfla_datapath #(.ITEMS_PER_BLOCK(ITEMS_PER_BLOCK), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_operation(op_q), .in_item_handle(handle_q), .sts(sts),
    .given_handle(rsp.payload.given_handle), .status(rsp.payload.status),
    .blocks_released(rsp.payload.blocks_released)
  );
endmodule

FILE: rtl/core/sfla_checker.sv
// Port-level checks on the slab allocator handshakes and results.
// Uses only the top-level ports; bound to slab_free_list_allocator_unit.
module sfla_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] given_handle,
  input logic [1:0] status,
  input logic [3:0] blocks_released
);
  import sfla_pkg::*;

  a_one_outstanding: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("input taken while result pending");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(given_handle))
    else $error("result dropped");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status != ST_RSVD) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> given_handle == 8'd0 && blocks_released == 4'd0)
    else $error("error result carries data");
endmodule

bind slab_free_list_allocator_unit sfla_checker u_sfla_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .given_handle(rsp.payload.given_handle), .status(rsp.payload.status),
  .blocks_released(rsp.payload.blocks_released)
);

FILE: tb/sv/tb_slab_free_list_allocator_unit.sv
// Self-checking testbench for slab_free_list_allocator_unit: random and directed
// allocate/free/squeeze traffic checked against an in-bench slab allocator model.
// Depends on sfla_pkg, sfla_stream_if and the allocator RTL.
module tb_slab_free_list_allocator_unit;
  import sfla_pkg::*;

  localparam int IPB = ITEMS_PER_BLOCK_DEF;
  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam int NITEMS = IPB * NBLK;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    op_t operation;
    logic [7:0] item_handle;
  } alloc_req_t;

  typedef struct packed {
    logic [7:0] given_handle;
    logic [1:0] status;
    logic [3:0] blocks_released;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst;

  sfla_stream_if #(.payload_t(alloc_req_t)) req (clk);
  sfla_stream_if #(.payload_t(alloc_rsp_t)) rsp (clk);

  slab_free_list_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  logic [3:0] link_ram [NITEMS];
  logic [3:0] head_idx [NBLK];
  logic [3:0] free_items [NBLK];
  logic slot_live [NBLK];
  logic [3:0] creation_order [NBLK];
  int unsigned live_blocks;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t awaited_rsps[$];
  logic [7:0] held_handles[$];
  int unsigned cyc = 0;
  int unsigned quiet_cycles;
  int unsigned errors = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void build_slot(int unsigned slot);
    for (int i = 0; i < IPB; i++) begin
      link_ram[slot * IPB + i] = 4'((i + 1) & 15);
    end
    head_idx[slot] = 4'd0;
    free_items[slot] = 4'(IPB);
    slot_live[slot] = 1'b1;
  endfunction

  function automatic void reset_slabs();
    for (int i = 0; i < NITEMS; i++) begin
      link_ram[i] = 4'd0;
    end
    for (int s = 0; s < NBLK; s++) begin
      head_idx[s] = 4'd0;
      free_items[s] = 4'd0;
      slot_live[s] = 1'b0;
      creation_order[s] = 4'd0;
    end
    build_slot(0);
    live_blocks = 1;
  endfunction

  function automatic logic [7:0] pop_slot(int unsigned slot);
    int unsigned idx;
    idx = head_idx[slot] % IPB;
    head_idx[slot] = link_ram[slot * IPB + idx];
    free_items[slot] = free_items[slot] - 4'd1;
    return 8'(slot * IPB + idx);
  endfunction

  function automatic alloc_rsp_t slab_step(alloc_req_t r);
    alloc_rsp_t o;
    int unsigned slot;
    int unsigned kept;
    int unsigned released;
    bit found;
    o = '0;
    found = 1'b0;
    case (r.operation)
      OP_ALLOC: begin
        for (int k = 0; k < live_blocks && k < NBLK && !found; k++) begin
          slot = creation_order[k];
          if (free_items[slot] != 0) begin
            o.given_handle = pop_slot(slot);
            found = 1'b1;
          end
        end
        if (!found) begin
          slot = NBLK;
          for (int s = NBLK - 1; s >= 0; s--) begin
            if (!slot_live[s]) slot = s;
          end
          if (slot >= NBLK || live_blocks >= NBLK) begin
            o.status = ST_EXHAUSTED;
          end else begin
            build_slot(slot);
            creation_order[live_blocks] = 4'(slot);
            live_blocks++;
            o.given_handle = pop_slot(slot);
          end
        end
      end
      OP_FREE: begin
        if (r.item_handle >= NITEMS || !slot_live[r.item_handle / IPB]) begin
          o.status = ST_BAD_FREE;
        end else begin
          slot = r.item_handle / IPB;
          link_ram[r.item_handle] = head_idx[slot];
          head_idx[slot] = 4'(r.item_handle % IPB);
          if (free_items[slot] < COUNT_MAX) free_items[slot] = free_items[slot] + 4'd1;
        end
      end
      OP_SQUEEZE: begin
        kept = 1;
        released = 0;
        for (int k = 1; k < live_blocks && k < NBLK; k++) begin
          slot = creation_order[k];
          if (slot != 0 && free_items[slot] == IPB) begin
            slot_live[slot] = 1'b0;
            free_items[slot] = 4'd0;
            head_idx[slot] = 4'd0;
            released++;
          end else begin
            creation_order[kept] = 4'(slot);
            kept++;
          end
        end
        for (int k = kept; k < NBLK; k++) begin
          creation_order[k] = 4'd0;
        end
        live_blocks = kept;
        o.blocks_released = 4'(released);
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic queue_op(op_t op, logic [7:0] handle);
    alloc_req_t r;
    alloc_rsp_t o;
    r.operation = op;
    r.item_handle = handle;
    o = slab_step(r);
    if (op == OP_ALLOC && o.status == ST_OK) held_handles.push_back(o.given_handle);
    if (op == OP_FREE && o.status == ST_OK) begin
      for (int i = 0; i < held_handles.size(); i++) begin
        if (held_handles[i] == handle) begin
          held_handles.delete(i);
          break;
        end
      end
    end
    pending_reqs.push_back(r);
    awaited_rsps.push_back(o);
  endtask

  task automatic free_held(int unsigned i);
    logic [7:0] h;
    h = held_handles[i];
    queue_op(OP_FREE, h);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      req.valid <= 1'b0;
      req.payload <= '0;
    end else if (!req.valid || req.ready) begin
      if (pending_reqs.size() > 0 && ((cyc % 5000) < 1200 || $urandom_range(99) >= 38)) begin
        req.valid <= 1'b1;
        req.payload <= pending_reqs.pop_front();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (rst) begin
      rsp.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      rsp.ready <= ((cyc % 5000) < 1200) || ($urandom_range(99) >= 38);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsps.size() == 0) begin
          $error("unexpected transaction: %p", rsp.payload);
          errors++;
        end else begin
          exp_rsp = awaited_rsps.pop_front();
          if (rsp.payload.given_handle !== exp_rsp.given_handle) begin
            $error("given_handle expected %0d actual %0d",
                   exp_rsp.given_handle, rsp.payload.given_handle);
            errors++;
          end
          if (rsp.payload.status !== exp_rsp.status) begin
            $error("status expected %0d actual %0d", exp_rsp.status, rsp.payload.status);
            errors++;
          end
          if (rsp.payload.blocks_released !== exp_rsp.blocks_released) begin
            $error("blocks_released expected %0d actual %0d",
                   exp_rsp.blocks_released, rsp.payload.blocks_released);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned pick;
    rst = 1'b1;
    reset_slabs();

    queue_op(OP_SQUEEZE, 8'd0);
    queue_op(OP_ALLOC, 8'd0);
    queue_op(OP_FREE, 8'd0);
    queue_op(OP_FREE, 8'd0);
    queue_op(OP_FREE, 8'd159);
    queue_op(OP_FREE, 8'd160);
    queue_op(OP_FREE, 8'd255);
    queue_op(OP_NONE, 8'hff);
    for (int i = 0; i < 12; i++) queue_op(OP_ALLOC, 8'h00);
    queue_op(OP_FREE, 8'd19);
    queue_op(OP_FREE, 8'd10);
    queue_op(OP_SQUEEZE, 8'haa);
    queue_op(OP_FREE, 8'd15);
    queue_op(OP_SQUEEZE, 8'h55);

    while (pending_reqs.size() + 0 < 1600 && awaited_rsps.size() < 1600) begin
      mode = $urandom_range(3);
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(99);
        case (mode)
          0: begin
            if (pick < 85 || held_handles.size() == 0) queue_op(OP_ALLOC, 8'($urandom));
            else free_held($urandom_range(held_handles.size() - 1));
          end
          1: begin
            if (pick < 70 && held_handles.size() > 0)
              free_held($urandom_range(held_handles.size() - 1));
            else if (pick < 82) queue_op(OP_SQUEEZE, 8'($urandom));
            else if (pick < 92) queue_op(OP_ALLOC, 8'($urandom));
            else queue_op(OP_FREE, 8'($urandom_range(255)));
          end
          default: begin
            if (pick < 40) queue_op(OP_ALLOC, 8'($urandom));
            else if (pick < 75 && held_handles.size() > 0)
              free_held($urandom_range(held_handles.size() - 1));
            else if (pick < 85) queue_op(OP_SQUEEZE, 8'($urandom));
            else if (pick < 95) queue_op(OP_FREE, 8'($urandom_range(NITEMS - 1)));
            else queue_op(OP_NONE, 8'($urandom));
          end
        endcase
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || awaited_rsps.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
